// ===== sv/bst_pkg.sv =====
`default_nettype none

package bst_pkg;

    // Store geometry: the store is organized as 64-bit words of eight bytes
    localparam int WORD_BITS  = 64;
    localparam int WORD_BYTES = 8;
    localparam int WORD_SH    = 6;
    localparam int BYTE_SH    = 3;

    // Field widths fixed by the interface
    localparam int CMD_W   = 3;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;

    // Defaults
    localparam int DEF_MAX_BITS   = 1024;
    localparam int RESET_BIT_CNT  = 1024;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_READ      = 3'd0,
        CMD_SET       = 3'd1,
        CMD_CLEAR     = 3'd2,
        CMD_SET_ALL   = 3'd3,
        CMD_CLEAR_ALL = 3'd4,
        CMD_FIND      = 3'd5
    } cmd_code_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_WIPE,
        ST_IDLE,
        ST_ACCESS,
        ST_FILL,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [INDEX_W-1:0] index;
    } cmd_item_t;

    typedef struct packed {
        logic               bit_value;
        logic               found;
        logic [INDEX_W-1:0] found_index;
    } res_item_t;

    // Write port control of the word store
    typedef struct packed {
        logic                  en;
        logic [WORD_BYTES-1:0] be;
        logic [WORD_BITS-1:0]  data;
    } store_wr_t;

    // Position of the lowest set bit of a word; zero for an empty word
    function automatic logic [WORD_SH-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
        logic [WORD_SH-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                pos = WORD_SH'(i);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

// ===== sv/bitmap_slot_tracker.sv =====
// bitmap_slot_tracker: bit store with single-bit access, bulk set/clear and
// a find-first-set search.
// Command channel (cmd_valid/cmd_ready/cmd) takes one item: a command and an
// index. Result channel (res_valid/res_ready/res) returns exactly one item per
// command, in order. cfg_wr_en/cfg_wr_data write the bit count; the user must
// do so only while the block is idle (not enforced); values above MAX_BITS
// are saturated. The store is a memory of 64-bit words with a registered read.
// Items are handled one at a time; steps from accept to result ready:
//   read/set/clear: read word, modify/write back, load result
//   set all/clear all: one word written per cycle over the covered words
//   find: one word scanned per cycle, stopping at the first hit
//   at or past the start byte.
// Unused commands and out-of-range read/set/clear indexes skip the store.
// After reset the store is wiped one word per cycle, and cmd_ready stays
// low until the wipe ends.
// The result sits in an output register; a new item is accepted while it
// waits. When the receiver stalls, a finished item holds in the controller
// until the output register frees up, and no further item is accepted.
`default_nettype none

module bitmap_slot_tracker #(
    parameter int MAX_BITS = bst_pkg::DEF_MAX_BITS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cmd_valid,
    output logic                             cmd_ready,
    input  wire bst_pkg::cmd_item_t          cmd,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output bst_pkg::res_item_t               res,
    input  wire logic                        cfg_wr_en,
    input  wire logic [bst_pkg::COUNT_W-1:0] cfg_wr_data
);
    import bst_pkg::*;

    localparam int WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW    = $clog2(MAX_BITS + 1);
    localparam int SW    = CW + 7;
    localparam int BW    = AW + BYTE_SH;
    localparam int RESET_N = (MAX_BITS < RESET_BIT_CNT) ? MAX_BITS : RESET_BIT_CNT;

    state_t              state_reg, state_next;
    logic [CW-1:0]       n_reg, n_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [INDEX_W-1:0]  idx_reg, idx_next;
    logic [BW-1:0]       sb_reg, sb_next;
    logic [AW:0]         addr_reg, addr_next;
    logic                bit_reg, bit_next;
    logic                found_reg, found_next;
    logic [INDEX_W-1:0]  fidx_reg, fidx_next;
    logic                res_valid_reg, res_valid_next;
    res_item_t           res_reg, res_next;

    store_wr_t            wr;
    logic [AW-1:0]        wr_addr;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [WORD_BITS-1:0] rd_data;

    logic [SW-1:0]        n_ext;
    logic [AW:0]          cov_words;
    logic [AW:0]          cov_last;
    logic [BW:0]          nbytes;
    logic [WORD_BYTES-1:0] be_last;
    logic                 accept;
    logic                 idx_inside;
    logic                 start_ok;
    logic                 at_last;
    logic [AW:0]          thr_word;
    logic [WORD_BITS-1:0] lim_mask;
    logic [WORD_BITS-1:0] ge_mask;
    logic [WORD_BITS-1:0] hit_any;
    logic [WORD_BITS-1:0] hit_ge;
    logic [WORD_BITS-1:0] mod_word;

    bst_store #(
        .WORDS (WORDS),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr      (wr),
        .wr_addr (wr_addr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Derive coverage from the bit count
    assign n_ext     = SW'(n_reg);
    assign cov_words = (AW+1)'((n_ext + SW'(WORD_BITS - 1)) >> WORD_SH);
    assign cov_last  = cov_words - (AW+1)'(1);
    assign nbytes    = (BW+1)'((n_ext + SW'(7)) >> BYTE_SH);
    assign be_last   = (nbytes[2:0] == 3'd0) ? '1 : ~({WORD_BYTES{1'b1}} << nbytes[2:0]);
    assign at_last   = (addr_reg == cov_last);

    // Decode the incoming index
    assign cmd_ready  = (state_reg == ST_IDLE);
    assign accept     = cmd_valid && cmd_ready;
    assign idx_inside = (32'(cmd.index) < 32'(MAX_BITS));
    assign start_ok   = idx_inside && (32'(cmd.index[INDEX_W-1:BYTE_SH]) < 32'(nbytes));

    // Masks for the word under scan
    assign thr_word = (AW+1)'(sb_reg[BW-1:BYTE_SH]);
    assign lim_mask = (!at_last || n_ext[WORD_SH-1:0] == '0) ? '1
                    : ~({WORD_BITS{1'b1}} << n_ext[WORD_SH-1:0]);
    always_comb
    begin
        if (addr_reg > thr_word)
        begin
            ge_mask = '1;
        end
        else if (addr_reg == thr_word)
        begin
            ge_mask = {WORD_BITS{1'b1}} << {sb_reg[BYTE_SH-1:0], 3'b000};
        end
        else
        begin
            ge_mask = '0;
        end
    end
    assign hit_any = rd_data & lim_mask;
    assign hit_ge  = hit_any & ge_mask;

    // Single-bit modify of the fetched word
    always_comb
    begin
        mod_word = rd_data;
        mod_word[idx_reg[WORD_SH-1:0]] = (cmd_reg == CMD_SET);
    end

    // Controller: next state, store access and result capture
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        sb_next        = sb_reg;
        addr_next      = addr_reg;
        bit_next       = bit_reg;
        found_next     = found_reg;
        fidx_next      = fidx_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        wr             = '0;
        wr_addr        = addr_reg[AW-1:0];
        rd_en          = 1'b0;
        rd_addr        = addr_reg[AW-1:0];

        // Saturate the configured count
        if (cfg_wr_en)
        begin
            n_next = (32'(cfg_wr_data) > 32'(MAX_BITS)) ? CW'(MAX_BITS) : CW'(cfg_wr_data);
        end

        case (state_reg)
            ST_WIPE:
            begin
                wr.en     = 1'b1;
                wr.be     = '1;
                wr.data   = '0;
                addr_next = addr_reg + (AW+1)'(1);
                if (addr_reg == (AW+1)'(WORDS - 1))
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = cmd.command;
                    idx_next   = cmd.index;
                    bit_next   = 1'b0;
                    found_next = 1'b0;
                    fidx_next  = '0;
                    addr_next  = '0;
                    sb_next    = start_ok ? BW'(cmd.index[INDEX_W-1:BYTE_SH]) : '0;
                    state_next = ST_EMIT;
                    if (cmd.command == CMD_READ || cmd.command == CMD_SET
                        || cmd.command == CMD_CLEAR)
                    begin
                        if (idx_inside)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = AW'(cmd.index[INDEX_W-1:WORD_SH]);
                            state_next = ST_ACCESS;
                        end
                    end
                    else if (cmd.command == CMD_SET_ALL || cmd.command == CMD_CLEAR_ALL)
                    begin
                        if (cov_words != '0)
                        begin
                            state_next = ST_FILL;
                        end
                    end
                    else if (cmd.command == CMD_FIND)
                    begin
                        if (cov_words != '0)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            state_next = ST_SCAN;
                        end
                    end
                end
            end

            ST_ACCESS:
            begin
                // Read returns the bit; set and clear write the word back
                wr_addr = AW'(idx_reg[INDEX_W-1:WORD_SH]);
                if (cmd_reg == CMD_READ)
                begin
                    bit_next = rd_data[idx_reg[WORD_SH-1:0]];
                end
                else
                begin
                    wr.en   = 1'b1;
                    wr.be   = '1;
                    wr.data = mod_word;
                end
                state_next = ST_EMIT;
            end

            ST_FILL:
            begin
                wr.en     = 1'b1;
                wr.be     = at_last ? be_last : '1;
                wr.data   = (cmd_reg == CMD_SET_ALL) ? '1 : '0;
                addr_next = addr_reg + (AW+1)'(1);
                if (at_last)
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_SCAN:
            begin
                // Fetch the next word while checking this one
                if (!at_last)
                begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(addr_reg + (AW+1)'(1));
                end
                addr_next = addr_reg + (AW+1)'(1);
                if (hit_ge != '0)
                begin
                    found_next = 1'b1;
                    fidx_next  = INDEX_W'({addr_reg[AW-1:0], lowest_set(hit_ge)});
                    state_next = ST_EMIT;
                end
                else
                begin
                    // Keep the lowest hit for the wrapped part of the search
                    if (hit_any != '0 && !found_reg)
                    begin
                        found_next = 1'b1;
                        fidx_next  = INDEX_W'({addr_reg[AW-1:0], lowest_set(hit_any)});
                    end
                    if (at_last)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_EMIT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next        = 1'b1;
                    res_next.bit_value    = bit_reg;
                    res_next.found        = found_reg;
                    res_next.found_index  = fidx_reg;
                    state_next            = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_WIPE;
            n_reg         <= CW'(RESET_N);
            addr_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            addr_reg      <= addr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Item payload
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        idx_reg   <= idx_next;
        sb_reg    <= sb_next;
        bit_reg   <= bit_next;
        found_reg <= found_next;
        fidx_reg  <= fidx_next;
        res_reg   <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// ===== sv/bst_store.sv =====
`default_nettype none

module bst_store #(
    parameter int WORDS = 16,
    parameter int AW    = 4
) (
    input  wire logic                          clk,
    input  wire bst_pkg::store_wr_t            wr,
    input  wire logic [AW-1:0]                 wr_addr,
    input  wire logic                          rd_en,
    input  wire logic [AW-1:0]                 rd_addr,
    output logic [bst_pkg::WORD_BITS-1:0]      rd_data
);
    import bst_pkg::*;

    logic [WORD_BITS-1:0] mem [WORDS];

    // Write enabled bytes of one word
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            for (int b = 0; b < WORD_BYTES; b++)
            begin
                if (wr.be[b])
                begin
                    mem[wr_addr][b*8 +: 8] <= wr.data[b*8 +: 8];
                end
            end
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/bst_checker.sv =====
`default_nettype none

module bst_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               cmd_valid,
    input wire logic               cmd_ready,
    input wire logic               res_valid,
    input wire logic               res_ready,
    input wire bst_pkg::res_item_t res
);
    import bst_pkg::*;

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // Drop ready after taking an item
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("item taken while busy");

    // Report no index without a hit
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.found |-> res.found_index == '0)
        else $error("index reported without a hit");

    // Keep read and search results apart
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res.bit_value && res.found))
        else $error("bit value and found both set");

endmodule

bind bitmap_slot_tracker bst_checker u_bst_checker (.*);

`default_nettype wire

// ===== verif/bitmap_slot_tracker_tb.sv =====
module bitmap_slot_tracker_tb;
    import bst_pkg::*;

    localparam int STORE_BYTES    = DEF_MAX_BITS / 8;
    localparam int MAX_INDEX      = (1 << INDEX_W) - 1;
    localparam int CLK_HALF       = 6;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int RANDOM_ITEMS   = 75;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 24;
    localparam int HOLD_AT_FIRST  = 150;
    localparam int HOLD_AT_SECOND = 450;

    // Command codes the block leaves unused
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    // One queued entry: a command item, or a marker that pauses the sender
    // until every outstanding result has come back
    typedef struct packed {
        logic      drain;
        cmd_item_t item;
    } pending_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_ready;
    cmd_item_t          cmd = '0;
    logic               res_valid;
    logic               res_ready = 1'b0;
    res_item_t          res;
    logic               cfg_wr_en = 1'b0;
    logic [COUNT_W-1:0] cfg_wr_data = COUNT_W'(RESET_BIT_CNT);

    // Shadow copy of the bit store and the bit count
    logic [7:0]  slot_bytes [STORE_BYTES];
    int unsigned tracked_bits = RESET_BIT_CNT;

    pending_t    pending_cmds [$];
    res_item_t   awaited_results [$];
    int unsigned count_plan [$];

    int fail_count = 0;
    int cmd_tally [8];
    int find_hits = 0;

    // Sender state
    int        burst_left = 0;
    int        gap_left = 0;
    logic      drv_valid_nx;
    cmd_item_t drv_cmd_nx;
    pending_t  drv_head;

    // Receiver state
    int          results_taken = 0;
    int          hold_left = 0;
    int          last_hold_at = -1;
    int          pattern_age = 0;
    logic [15:0] ready_pattern = 16'hffff;
    logic        rcv_ready_nx;

    res_item_t due_result;

    bitmap_slot_tracker #(
        .MAX_BITS(DEF_MAX_BITS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd(cmd),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res(res),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Apply one command to the shadow store and return the result it yields
    function automatic res_item_t apply_command(input cmd_item_t it);
        res_item_t   r;
        int unsigned lim;
        int unsigned nbytes;
        int unsigned byte_at;
        int unsigned pos;
        int unsigned left;
        int unsigned k;
        int unsigned at;
        logic [7:0]  mask;
        logic        done;
        r = '0;
        lim = (tracked_bits > DEF_MAX_BITS) ? DEF_MAX_BITS : tracked_bits;
        nbytes = (lim + 7) / 8;
        byte_at = it.index / 8;
        mask = 8'h01 << it.index[2:0];
        done = 1'b0;
        case (it.command)
            CMD_READ: r.bit_value = ((slot_bytes[byte_at] & mask) != 8'h00);
            CMD_SET: slot_bytes[byte_at] = slot_bytes[byte_at] | mask;
            CMD_CLEAR: slot_bytes[byte_at] = slot_bytes[byte_at] & ~mask;
            CMD_SET_ALL:
            begin
                for (int b = 0; b < nbytes; b++)
                    slot_bytes[b] = 8'hff;
            end
            CMD_CLEAR_ALL:
            begin
                for (int b = 0; b < nbytes; b++)
                    slot_bytes[b] = 8'h00;
            end
            CMD_FIND:
            begin
                // Start at the byte of the index, or at byte 0 when it lies
                // past the covered bytes; visit each covered byte once
                pos = (byte_at < nbytes) ? byte_at : 0;
                for (left = nbytes; left > 0 && !done; left--)
                begin
                    if (slot_bytes[pos] != 8'h00)
                    begin
                        k = 0;
                        while (k < 7 && !slot_bytes[pos][k])
                            k++;
                        at = pos * 8 + k;
                        if (at < lim)
                        begin
                            r.found = 1'b1;
                            r.found_index = INDEX_W'(at);
                            done = 1'b1;
                        end
                    end
                    pos = (pos + 1 == nbytes) ? 0 : pos + 1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Drive command items in bursts; predict each item as it is accepted
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
        end
        else
        begin
            drv_valid_nx = cmd_valid;
            drv_cmd_nx = cmd;
            if (cmd_valid && cmd_ready)
            begin
                awaited_results.push_back(apply_command(cmd));
                cmd_tally[cmd.command]++;
                drv_valid_nx = 1'b0;
            end
            if (!drv_valid_nx)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_cmds.size() > 0)
                begin
                    if (pending_cmds[0].drain)
                    begin
                        if (awaited_results.size() == 0)
                            drv_head = pending_cmds.pop_front();
                    end
                    else
                    begin
                        drv_head = pending_cmds.pop_front();
                        drv_cmd_nx = drv_head.item;
                        drv_valid_nx = 1'b1;
                        if (burst_left > 1)
                        begin
                            burst_left--;
                        end
                        else
                        begin
                            burst_left = $urandom_range(1, 40);
                            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                        end
                    end
                end
            end
            cmd_valid <= drv_valid_nx;
            cmd <= drv_cmd_nx;
        end
    end

    // Stall the result side on a rotating pattern, with two long hold-offs
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            if (res_valid && res_ready)
                results_taken++;
            if (hold_left > 0)
            begin
                hold_left--;
                rcv_ready_nx = 1'b0;
            end
            else if ((results_taken == HOLD_AT_FIRST || results_taken == HOLD_AT_SECOND)
                     && last_hold_at != results_taken)
            begin
                last_hold_at = results_taken;
                hold_left = LONG_HOLD;
                rcv_ready_nx = 1'b0;
            end
            else
            begin
                if (pattern_age == 0)
                begin
                    ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff
                                                                : (16'($urandom) | 16'h0101);
                    pattern_age = 63;
                end
                else
                begin
                    pattern_age--;
                end
                rcv_ready_nx = ready_pattern[0];
                ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
            end
            res_ready <= rcv_ready_nx;
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result with nothing outstanding: bit_value=%0d found=%0d found_index=%0d",
                       res.bit_value, res.found, res.found_index);
                fail_count++;
            end
            else
            begin
                due_result = awaited_results.pop_front();
                if (due_result.found)
                    find_hits++;
                if (res.bit_value !== due_result.bit_value)
                begin
                    $error("bit_value: expected %0d, got %0d", due_result.bit_value, res.bit_value);
                    fail_count++;
                end
                if (res.found !== due_result.found)
                begin
                    $error("found: expected %0d, got %0d", due_result.found, res.found);
                    fail_count++;
                end
                if (res.found_index !== due_result.found_index)
                begin
                    $error("found_index: expected %0d, got %0d",
                           due_result.found_index, res.found_index);
                    fail_count++;
                end
            end
        end
    end

    task automatic queue_item(input logic [CMD_W-1:0] code, input int unsigned idx);
        pending_t p;
        p.drain = 1'b0;
        p.item.command = code;
        p.item.index = INDEX_W'(idx);
        pending_cmds.push_back(p);
    endtask

    task automatic queue_drain();
        pending_t p;
        p = '0;
        p.drain = 1'b1;
        pending_cmds.push_back(p);
    endtask

    function automatic logic [CMD_W-1:0] pick_command();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return CMD_READ;
        if (r < 45)
            return CMD_SET;
        if (r < 64)
            return CMD_CLEAR;
        if (r < 69)
            return CMD_SET_ALL;
        if (r < 74)
            return CMD_CLEAR_ALL;
        if (r < 97)
            return CMD_FIND;
        return ($urandom_range(0, 1) == 0) ? CMD_SPARE_A : CMD_SPARE_B;
    endfunction

    // Favor indexes near the tracked range, with edges and full-range picks
    function automatic int unsigned pick_index();
        int unsigned lim;
        int unsigned r;
        lim = (tracked_bits > DEF_MAX_BITS) ? DEF_MAX_BITS : tracked_bits;
        r = $urandom_range(0, 99);
        if (r < 45)
            return $urandom_range(0, (lim + 15 > MAX_INDEX) ? MAX_INDEX : lim + 15);
        if (r < 55)
        begin
            case ($urandom_range(0, 3))
                0: return 0;
                1: return MAX_INDEX;
                2: return (lim == 0) ? 0 : lim - 1;
                default: return (lim > MAX_INDEX) ? MAX_INDEX : lim;
            endcase
        end
        return $urandom_range(0, MAX_INDEX);
    endfunction

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2 || $urandom_range(0, 49) == 0)
                queue_drain();
            queue_item(pick_command(), pick_index());
        end
    endtask

    // Hold until nothing is queued, offered or outstanding
    task automatic wait_idle();
        @(negedge clk);
        while (pending_cmds.size() != 0 || cmd_valid || awaited_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_count(input int unsigned value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= COUNT_W'(value);
        tracked_bits = value & ((1 << COUNT_W) - 1);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        for (int b = 0; b < STORE_BYTES; b++)
            slot_bytes[b] = 8'h00;
        count_plan = '{0, 1, 13, 2047, 1023, 64};
        count_plan.push_back($urandom_range(2, 1022));
        count_plan.push_back($urandom_range(1025, 2046));
        count_plan.push_back(1024);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items at the reset count, store starting clear
        queue_item(CMD_READ, 0);
        queue_item(CMD_FIND, 0);
        queue_item(CMD_SET, 0);
        queue_item(CMD_SET, MAX_INDEX);
        queue_item(CMD_READ, MAX_INDEX);
        queue_item(CMD_READ, 0);
        queue_item(CMD_FIND, 512);
        queue_item(CMD_FIND, 1020);
        queue_item(CMD_CLEAR, 0);
        queue_item(CMD_FIND, MAX_INDEX);
        queue_item(CMD_CLEAR, MAX_INDEX);
        queue_item(CMD_SET, 517);
        queue_item(CMD_SET, 519);
        // lower bit of the start byte is still returned
        queue_item(CMD_FIND, 518);
        // start past the only set byte, so the search wraps
        queue_item(CMD_FIND, 600);
        queue_item(CMD_SET, 'h2aa);
        queue_item(CMD_READ, 'h2aa);
        queue_item(CMD_READ, 'h155);
        queue_item(CMD_SPARE_A, MAX_INDEX);
        queue_item(CMD_SPARE_B, 'h155);
        queue_item(CMD_SET_ALL, 0);
        queue_item(CMD_FIND, 300);
        queue_item(CMD_READ, 777);
        queue_item(CMD_CLEAR_ALL, MAX_INDEX);
        queue_item(CMD_FIND, 0);
        wait_idle();

        // Random items under each bit count, written while idle
        foreach (count_plan[p])
        begin
            write_count(count_plan[p]);
            queue_random(RANDOM_ITEMS);
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("ran %0d bit-count settings: %0d reads, %0d sets, %0d clears, %0d fills, %0d bulk clears",
                 count_plan.size() + 1, cmd_tally[CMD_READ], cmd_tally[CMD_SET],
                 cmd_tally[CMD_CLEAR], cmd_tally[CMD_SET_ALL], cmd_tally[CMD_CLEAR_ALL]);
        $display("%0d searches (%0d hit a set bit), %0d unused codes",
                 cmd_tally[CMD_FIND], find_hits, cmd_tally[CMD_SPARE_A] + cmd_tally[CMD_SPARE_B]);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #(2 * CLK_HALF * TIMEOUT_CYCLES);
        $display("timeout: block stopped responding");
        $display("end of test: mismatches");
        $finish;
    end

endmodule
